[design/afr_pkg.sv]
// Shared types, constants and the byte-wide CRC update for the frame receiver.
package afr_pkg;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int CRC_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hFE;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h00;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_HEADER_BYTE   = 1'b0,
      CSR_BOARD_ADDRESS = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_SKIP      = 3'd0,
      STATUS_TAKEN     = 3'd1,
      STATUS_GOOD      = 3'd2,
      STATUS_CRC_BAD   = 3'd3,
      STATUS_ADDR_BAD  = 3'd4
   } frame_status_type;

   // Classified byte handed from the front end to the frame engine.
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              is_header;
      logic              is_address;
   } byte_item_type;

   typedef struct packed {
      frame_status_type   frame_status;
      logic [BYTE_W-1:0]  command_code;
      logic [INDEX_W-1:0] byte_position;
      logic [COUNT_W-1:0] good_frame_count;
   } result_type;

   // Reflected Modbus CRC-16, one byte per call.
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[design/addressed_frame_receiver_crc16.sv]
// Top level of the addressed fixed-length frame receiver with CRC-16 check.
// Receives serial bytes and delivers exactly one result per byte, in order.
// A frame is header byte (csr index 0, reset 0xFE), board address
// (csr index 1, reset 0x00), then payload, FRAME_LENGTH bytes in total;
// the last two bytes are the Modbus CRC-16 (poly 0xA001 reflected, init
// 0xFFFF, low byte first) over all earlier bytes, header included. Status
// per byte: 0 skipped while hunting for a header, 1 taken, 2 frame good,
// 3 CRC mismatch, 4 address mismatch. command_code is the third byte of
// the last good frame; good_frame_count wraps at 65536. Throughput is one
// transfer per cycle in and out while neither side stalls: the CRC
// advances a whole byte per cycle in the frame engine. An input
// transfer's result passes through the intake queue, the frame engine and
// the result queue before it shows on the rsp_ ports. Both queues are two
// deep; a result-side stall can back up to req_full. Write configuration
// only while no results are pending.
module addressed_frame_receiver_crc16 #(
   parameter int FRAME_LENGTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // received bytes
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [afr_pkg::BYTE_W-1:0]   req_rx_byte,
   // per-byte results
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [afr_pkg::STATUS_W-1:0] rsp_frame_status,
   output logic [afr_pkg::BYTE_W-1:0]   rsp_command_code,
   output logic [afr_pkg::INDEX_W-1:0]  rsp_byte_position,
   output logic [afr_pkg::COUNT_W-1:0]  rsp_good_frame_count,
   // configuration
   input  logic                         csr_write_enable,
   input  logic [0:0]                   csr_index,
   input  logic [afr_pkg::BYTE_W-1:0]   csr_write_data
);
   import afr_pkg::*;

   byte_item_type front_item;
   byte_item_type mid_item;
   logic          mid_full, mid_empty, mid_pop;
   result_type    engine_result;
   result_type    out_result;
   logic          out_full;

   afr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rx_byte          (req_rx_byte),
      .item             (front_item)
   );

   // intake queue between classifier and frame engine
   afr_fifo #(
      .WIDTH ($bits(byte_item_type)),
      .DEPTH (2)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   afr_back #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!mid_empty),
      .item        (mid_item),
      .item_take   (mid_pop),
      .result_full (out_full),
      .result      (engine_result)
   );

   // result queue; every engine step pushes one result
   afr_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_pop),
      .push_data (engine_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   assign req_full             = mid_full;
   assign rsp_frame_status     = out_result.frame_status;
   assign rsp_command_code     = out_result.command_code;
   assign rsp_byte_position    = out_result.byte_position;
   assign rsp_good_frame_count = out_result.good_frame_count;

endmodule

[design/afr_fifo.sv]
// Small register-based queue used between the pipeline parts.
module afr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

   logic [WIDTH-1:0]   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == COUNT_MAX);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/afr_front.sv]
// Front end: holds the match registers and tags each received byte.
module afr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [afr_pkg::BYTE_W-1:0] csr_write_data,
   input  logic [afr_pkg::BYTE_W-1:0] rx_byte,
   output afr_pkg::byte_item_type     item
);
   import afr_pkg::*;

   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         address_ff <= ADDRESS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_BYTE:   header_ff  <= csr_write_data;
            CSR_BOARD_ADDRESS: address_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // User makes config changes only while idle; tags set at intake.
   always_comb begin
      item.rx_byte    = rx_byte;
      item.is_header  = (rx_byte == header_ff);
      item.is_address = (rx_byte == address_ff);
   end

endmodule

[design/afr_back.sv]
// Frame engine: phase tracking, running CRC, check and counters.
module afr_back #(
   parameter int FRAME_LENGTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  afr_pkg::byte_item_type item,
   output logic                   item_take,
   input  logic                   result_full,
   output afr_pkg::result_type    result
);
   import afr_pkg::*;

   localparam logic [INDEX_W-1:0] LAST_IDX    = INDEX_W'(FRAME_LENGTH - 1);
   localparam logic [INDEX_W-1:0] CRC_LO_IDX  = INDEX_W'(FRAME_LENGTH - 2);
   localparam logic [INDEX_W-1:0] COMMAND_IDX = INDEX_W'(2);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_ADDR,
      PH_READ
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [BYTE_W-1:0]  crc_low_ff, crc_low_in;
   logic [BYTE_W-1:0]  command_ff, command_in;
   logic [BYTE_W-1:0]  pending_ff, pending_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]   crc_next;
   logic               crc_ok;
   frame_status_type   status;
   logic [INDEX_W-1:0] position;

   assign item_take = item_valid && !result_full;
   assign crc_next  = crc16_byte((phase_ff == PH_WAIT) ? CRC_INIT : crc_ff, item.rx_byte);
   assign crc_ok    = (item.rx_byte == crc_ff[CRC_W-1:BYTE_W]) &&
                      (crc_low_ff == crc_ff[BYTE_W-1:0]);

   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      command_in = command_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      status     = STATUS_SKIP;
      position   = '0;
      if (item_take) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (item.is_header) begin
                  crc_in   = crc_next;
                  index_in = INDEX_W'(1);
                  phase_in = PH_ADDR;
                  status   = STATUS_TAKEN;
               end
            end
            PH_ADDR: begin
               position = INDEX_W'(1);
               if (item.is_address) begin
                  crc_in   = crc_next;
                  index_in = INDEX_W'(2);
                  phase_in = PH_READ;
                  status   = STATUS_TAKEN;
               end else begin
                  phase_in = PH_WAIT;
                  index_in = '0;
                  crc_in   = CRC_INIT;
                  status   = STATUS_ADDR_BAD;
               end
            end
            PH_READ: begin
               position = index_ff;
               if (index_ff >= LAST_IDX) begin
                  if (crc_ok) begin
                     command_in = pending_ff;
                     count_in   = count_ff + 1'b1;
                     status     = STATUS_GOOD;
                  end else begin
                     status     = STATUS_CRC_BAD;
                  end
                  phase_in = PH_WAIT;
                  index_in = '0;
                  crc_in   = CRC_INIT;
               end else begin
                  if (index_ff == CRC_LO_IDX) begin
                     crc_low_in = item.rx_byte;
                  end else begin
                     crc_in = crc_next;
                  end
                  if (index_ff == COMMAND_IDX) begin
                     pending_in = item.rx_byte;
                  end
                  index_in = index_ff + 1'b1;
                  status   = STATUS_TAKEN;
               end
            end
            default: begin
               phase_in = PH_WAIT;
               index_in = '0;
               crc_in   = CRC_INIT;
            end
         endcase
      end
      result.frame_status     = status;
      result.command_code     = command_in;
      result.byte_position    = position;
      result.good_frame_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         index_ff   <= '0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= '0;
         command_ff <= '0;
         pending_ff <= '0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         command_ff <= command_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule

[design/afr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
module afr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_full,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [afr_pkg::STATUS_W-1:0] rsp_frame_status,
   input logic [afr_pkg::INDEX_W-1:0]  rsp_byte_position,
   input logic [afr_pkg::COUNT_W-1:0]  rsp_good_frame_count
);
   import afr_pkg::*;

   logic [COUNT_W-1:0] seen_count_ff;
   logic               rsp_xfer;
   logic               is_good;

   assign rsp_xfer = !rsp_empty && rsp_pop;
   assign is_good  = (rsp_frame_status == STATUS_GOOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
      end else if (rsp_xfer) begin
         seen_count_ff <= rsp_good_frame_count;
      end
   end

   a_reset_drains: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_frame_status <= STATUS_ADDR_BAD))
      else $error("undefined frame status");

   a_skip_position: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_status == STATUS_SKIP) |-> (rsp_byte_position == '0))
      else $error("skipped byte with nonzero position");

   a_count_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && is_good) |-> (rsp_good_frame_count == seen_count_ff + 1'b1))
      else $error("good frame did not advance count by one");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !is_good) |-> (rsp_good_frame_count == seen_count_ff))
      else $error("count changed without a good frame");

endmodule

bind addressed_frame_receiver_crc16 afr_checker u_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the addressed CRC-16 frame receiver.
module testbench;
   import afr_pkg::*;

   localparam int FRAME_LEN       = 8;
   localparam int DIRECTED_ROWS   = 23;
   localparam int PHASES          = 7;
   localparam int BYTES_PER_PHASE = 200;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 20;

   // Receive phases of the predictor.
   typedef enum logic [1:0] {
      HUNT_HEADER,
      CHECK_ADDRESS,
      COLLECT_BODY
   } link_phase_type;

   // How a directed row gets its byte: typed in, or the CRC of the rows before it.
   typedef enum logic [1:0] {
      ROW_LITERAL,
      ROW_CRC_LOW,
      ROW_CRC_HIGH,
      ROW_CRC_HIGH_BAD
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [7:0]        value;
      bit                typed;
      frame_status_type  want_status;
      logic [7:0]        want_command;
      logic [7:0]        want_position;
      logic [15:0]       want_count;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [STATUS_W-1:0] rsp_frame_status;
   logic [BYTE_W-1:0]   rsp_command_code;
   logic [INDEX_W-1:0]  rsp_byte_position;
   logic [COUNT_W-1:0]  rsp_good_frame_count;
   logic                csr_write_enable;
   logic [0:0]          csr_index;
   logic [BYTE_W-1:0]   csr_write_data;

   // Typed expectation that travels with the byte on the request port.
   bit                  plan_typed;
   result_type          plan_want;

   // Predictor state and its copy of the two registers.
   link_phase_type      link_phase;
   logic [7:0]          link_index;
   logic [15:0]         link_crc;
   logic [7:0]          crc_low_seen;
   logic [7:0]          last_command;
   logic [7:0]          command_in_flight;
   logic [15:0]         frames_good;
   logic [7:0]          header_value;
   logic [7:0]          address_value;

   result_type          frame_results_due[$];
   int unsigned         mismatch_count;

   // Test control shared by the sender, the receiver and the sequence.
   bit                  sender_steady;
   bit                  drain_steady;
   bit                  hold_off_request;
   logic [7:0]          frame_bytes[$];

   // Directed sequence at reset settings (header 0xFE, address 0x00).
   plan_row_type directed_plan [0:DIRECTED_ROWS-1] = '{
      // stray bytes while hunting, both extremes
      '{ROW_LITERAL,      8'h00, 1'b1, STATUS_SKIP,     8'h00, 8'd0, 16'd0},
      '{ROW_LITERAL,      8'hFF, 1'b1, STATUS_SKIP,     8'h00, 8'd0, 16'd0},
      // header, then a wrong address that equals the header: not a new start
      '{ROW_LITERAL,      8'hFE, 1'b1, STATUS_TAKEN,    8'h00, 8'd0, 16'd0},
      '{ROW_LITERAL,      8'hFE, 1'b1, STATUS_ADDR_BAD, 8'h00, 8'd1, 16'd0},
      '{ROW_LITERAL,      8'h00, 1'b1, STATUS_SKIP,     8'h00, 8'd0, 16'd0},
      // good frame, command 0xA5
      '{ROW_LITERAL,      8'hFE, 1'b1, STATUS_TAKEN,    8'h00, 8'd0, 16'd0},
      '{ROW_LITERAL,      8'h00, 1'b1, STATUS_TAKEN,    8'h00, 8'd1, 16'd0},
      '{ROW_LITERAL,      8'hA5, 1'b1, STATUS_TAKEN,    8'h00, 8'd2, 16'd0},
      '{ROW_LITERAL,      8'h00, 1'b1, STATUS_TAKEN,    8'h00, 8'd3, 16'd0},
      '{ROW_LITERAL,      8'hFF, 1'b1, STATUS_TAKEN,    8'h00, 8'd4, 16'd0},
      '{ROW_LITERAL,      8'h5A, 1'b1, STATUS_TAKEN,    8'h00, 8'd5, 16'd0},
      '{ROW_CRC_LOW,      8'h00, 1'b0, STATUS_SKIP,     8'h00, 8'd0, 16'd0},
      '{ROW_CRC_HIGH,     8'h00, 1'b1, STATUS_GOOD,     8'hA5, 8'd7, 16'd1},
      // frame with a broken CRC high byte: command and count hold
      '{ROW_LITERAL,      8'hFE, 1'b1, STATUS_TAKEN,    8'hA5, 8'd0, 16'd1},
      '{ROW_LITERAL,      8'h00, 1'b1, STATUS_TAKEN,    8'hA5, 8'd1, 16'd1},
      '{ROW_LITERAL,      8'h3C, 1'b1, STATUS_TAKEN,    8'hA5, 8'd2, 16'd1},
      '{ROW_LITERAL,      8'h81, 1'b1, STATUS_TAKEN,    8'hA5, 8'd3, 16'd1},
      '{ROW_LITERAL,      8'h7E, 1'b1, STATUS_TAKEN,    8'hA5, 8'd4, 16'd1},
      '{ROW_LITERAL,      8'h18, 1'b1, STATUS_TAKEN,    8'hA5, 8'd5, 16'd1},
      '{ROW_CRC_LOW,      8'h00, 1'b0, STATUS_SKIP,     8'h00, 8'd0, 16'd0},
      '{ROW_CRC_HIGH_BAD, 8'h00, 1'b1, STATUS_CRC_BAD,  8'hA5, 8'd7, 16'd1},
      // address extreme after a frame
      '{ROW_LITERAL,      8'hFE, 1'b1, STATUS_TAKEN,    8'hA5, 8'd0, 16'd1},
      '{ROW_LITERAL,      8'hFF, 1'b1, STATUS_ADDR_BAD, 8'hA5, 8'd1, 16'd1}
   };

   // Register settings per random phase; the last phase gets random values.
   logic [7:0] phase_header  [0:PHASES-1] = '{8'hFE, 8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'h00};
   logic [7:0] phase_address [0:PHASES-1] = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hFF, 8'h00, 8'h00};

   addressed_frame_receiver_crc16 #(
      .FRAME_LENGTH(FRAME_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_command_code    (rsp_command_code),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_good_frame_count(rsp_good_frame_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #20000000;
      $display("[addressed_frame_receiver_crc16] ERROR");
      $finish;
   end

   // Bit-serial Modbus CRC: shift LSB first, fold in the reflected polynomial.
   function automatic logic [15:0] crc_shift_in(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int bit_n = 0; bit_n < 8; bit_n++) begin
         feedback = acc[0] ^ data[bit_n];
         acc = {1'b0, acc[15:1]};
         if (feedback) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   // Mostly back to back, often a short gap, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic void restart_hunt();
      link_phase = HUNT_HEADER;
      link_index = 8'd0;
      link_crc   = CRC_INIT;
   endfunction

   // Next-state and result for one accepted byte.
   function automatic result_type predict_frame_byte(input logic [7:0] rx);
      result_type       outcome;
      frame_status_type status;
      logic [7:0]       position;
      status   = STATUS_SKIP;
      position = 8'd0;
      case (link_phase)
         HUNT_HEADER: begin
            if (rx == header_value) begin
               link_crc   = crc_shift_in(CRC_INIT, rx);
               link_index = 8'd1;
               link_phase = CHECK_ADDRESS;
               status     = STATUS_TAKEN;
            end
         end
         CHECK_ADDRESS: begin
            position = 8'd1;
            if (rx == address_value) begin
               link_crc   = crc_shift_in(link_crc, rx);
               link_index = 8'd2;
               link_phase = COLLECT_BODY;
               status     = STATUS_TAKEN;
            end else begin
               restart_hunt();
               status = STATUS_ADDR_BAD;
            end
         end
         default: begin
            position = link_index;
            if (link_index >= FRAME_LEN - 1) begin
               // last byte: CRC high, checked together with the stored low byte
               if (rx == link_crc[15:8] && crc_low_seen == link_crc[7:0]) begin
                  last_command = command_in_flight;
                  frames_good  = frames_good + 16'd1;
                  status       = STATUS_GOOD;
               end else begin
                  status = STATUS_CRC_BAD;
               end
               restart_hunt();
            end else begin
               if (link_index == FRAME_LEN - 2) begin
                  crc_low_seen = rx;
               end else begin
                  link_crc = crc_shift_in(link_crc, rx);
               end
               if (link_index == 8'd2) begin
                  command_in_flight = rx;
               end
               link_index = link_index + 8'd1;
               status     = STATUS_TAKEN;
            end
         end
      endcase
      outcome.frame_status     = status;
      outcome.command_code     = last_command;
      outcome.byte_position    = position;
      outcome.good_frame_count = frames_good;
      return outcome;
   endfunction

   // Watches every edge: register writes and byte transfers feed the predictor,
   // result transfers are checked against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      result_type due;
      if (reset) begin
         restart_hunt();
         crc_low_seen      = 8'd0;
         last_command      = 8'd0;
         command_in_flight = 8'd0;
         frames_good       = 16'd0;
         header_value      = HEADER_RESET;
         address_value     = ADDRESS_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_HEADER_BYTE:   header_value  = csr_write_data;
               CSR_BOARD_ADDRESS: address_value = csr_write_data;
               default: ;
            endcase
         end
         // predict first, so a byte's entry is queued before this edge's result is checked
         if (req_push && !req_full) begin
            due = predict_frame_byte(req_rx_byte);
            if (plan_typed) begin
               due = plan_want;
            end
            frame_results_due.push_back(due);
         end
         if (rsp_pop && !rsp_empty) begin
            if (frame_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: status %0d command %02h position %0d count %0d",
                        $time, rsp_frame_status, rsp_command_code, rsp_byte_position,
                        rsp_good_frame_count);
            end else begin
               due = frame_results_due.pop_front();
               if (rsp_frame_status !== due.frame_status ||
                   rsp_command_code !== due.command_code ||
                   rsp_byte_position !== due.byte_position ||
                   rsp_good_frame_count !== due.good_frame_count) begin
                  mismatch_count++;
                  $display("%0t: mismatch: expected status %0d command %02h position %0d count %0d",
                           $time, due.frame_status, due.command_code, due.byte_position,
                           due.good_frame_count);
                  $display("%0t:           actual status %0d command %02h position %0d count %0d",
                           $time, rsp_frame_status, rsp_command_code, rsp_byte_position,
                           rsp_good_frame_count);
               end
            end
         end
      end
   end

   // Result side: random stalls, steady stretches, and one long hold-off on request.
   initial begin : result_drain
      int unsigned stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            // long hold-off so the block backs up and stalls its input
            hold_off_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left != 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            if (!drain_steady && $urandom_range(0, 99) < 30) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // One byte transfer; leaves push high when the next byte follows at once.
   task automatic offer_rx_byte(input logic [7:0] value, input bit typed,
                                input result_type want);
      int unsigned gap;
      req_push    <= 1'b1;
      req_rx_byte <= value;
      plan_typed  <= typed;
      plan_want   <= want;
      @(posedge clock);
      while (req_full) @(posedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_push    <= 1'b0;
         req_rx_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected result has been transferred.
   task automatic settle_until_drained();
      req_push <= 1'b0;
      @(posedge clock);
      wait (frame_results_due.size() == 0);
   endtask

   // Both registers back to back; enable stays high across the two writes.
   task automatic write_settings(input logic [7:0] header, input logic [7:0] address);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HEADER_BYTE;
      csr_write_data   <= header;
      @(posedge clock);
      csr_index        <= CSR_BOARD_ADDRESS;
      csr_write_data   <= address;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random body byte, biased toward the header value and the extremes.
   function automatic logic [7:0] pick_body_byte(input logic [7:0] header);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return header;
      end else if (roll < 20) begin
         return 8'h00;
      end else if (roll < 30) begin
         return 8'hFF;
      end
      return 8'($urandom);
   endfunction

   initial begin : sequence_main
      int          first_row;
      int unsigned counted;
      int unsigned roll;
      bit          paused_once;
      bit          counts;
      logic [15:0] crc;
      logic [7:0]  stim;
      logic [7:0]  hdr;
      logic [7:0]  adr;
      result_type  want;

      reset            = 1'b1;
      req_push         = 1'b0;
      req_rx_byte      = 8'h00;
      csr_write_enable = 1'b0;
      csr_index        = CSR_HEADER_BYTE;
      csr_write_data   = 8'h00;
      plan_typed       = 1'b0;
      plan_want        = '0;
      mismatch_count   = 0;
      sender_steady    = 1'b0;
      drain_steady     = 1'b0;
      hold_off_request = 1'b0;
      paused_once      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings; CRC rows are computed over the rows
      // just before them (low byte over the six preceding, high skips one more).
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         stim = directed_plan[row].value;
         if (directed_plan[row].kind != ROW_LITERAL) begin
            first_row = (directed_plan[row].kind == ROW_CRC_LOW) ?
                        row - (FRAME_LEN - 2) : row - (FRAME_LEN - 1);
            crc = CRC_INIT;
            for (int k = first_row; k < first_row + FRAME_LEN - 2; k++) begin
               crc = crc_shift_in(crc, directed_plan[k].value);
            end
            case (directed_plan[row].kind)
               ROW_CRC_LOW:  stim = crc[7:0];
               ROW_CRC_HIGH: stim = crc[15:8];
               default:      stim = crc[15:8] ^ 8'h80;
            endcase
         end
         want.frame_status     = directed_plan[row].want_status;
         want.command_code     = directed_plan[row].want_command;
         want.byte_position    = directed_plan[row].want_position;
         want.good_frame_count = directed_plan[row].want_count;
         offer_rx_byte(stim, directed_plan[row].typed, want);
      end
      settle_until_drained();

      // Random phases, each under its own register settings.
      for (int phase = 0; phase < PHASES; phase++) begin
         hdr = phase_header[phase];
         adr = phase_address[phase];
         if (phase == PHASES - 1) begin
            hdr = 8'($urandom);
            adr = 8'($urandom);
         end
         write_settings(hdr, adr);

         // phase 1: receiver holds off while the sender streams, to fill the block
         sender_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
         drain_steady  = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            hold_off_request = 1'b1;
         end

         counted = 0;
         while (counted < BYTES_PER_PHASE) begin
            // once, the sender pauses mid-phase until all results are back
            if (phase == 2 && !paused_once && counted >= BYTES_PER_PHASE / 2) begin
               paused_once = 1'b1;
               settle_until_drained();
            end
            frame_bytes.delete();
            roll   = $urandom_range(0, 99);
            counts = (roll >= 12);
            if (!counts) begin
               // line noise, sometimes the header or address value
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 4))
                     0:       frame_bytes.push_back(hdr);
                     1:       frame_bytes.push_back(adr);
                     default: frame_bytes.push_back(8'($urandom));
                  endcase
               end
            end else if (roll < 20) begin
               // wrong address
               frame_bytes.push_back(hdr);
               frame_bytes.push_back(adr ^ 8'($urandom_range(1, 255)));
            end else begin
               frame_bytes.push_back(hdr);
               frame_bytes.push_back(adr);
               if (roll < 28) begin
                  // cut short; the next frame's bytes land in this one
                  repeat ($urandom_range(0, FRAME_LEN - 4)) begin
                     frame_bytes.push_back(pick_body_byte(hdr));
                  end
               end else begin
                  repeat (FRAME_LEN - 4) begin
                     frame_bytes.push_back(pick_body_byte(hdr));
                  end
                  crc = CRC_INIT;
                  foreach (frame_bytes[k]) begin
                     crc = crc_shift_in(crc, frame_bytes[k]);
                  end
                  if (roll < 40) begin
                     // corrupt one of the two CRC bytes
                     if ($urandom_range(0, 1) == 0) begin
                        crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
                     end else begin
                        crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
                     end
                  end
                  frame_bytes.push_back(crc[7:0]);
                  frame_bytes.push_back(crc[15:8]);
               end
            end
            foreach (frame_bytes[k]) begin
               offer_rx_byte(frame_bytes[k], 1'b0, '0);
            end
            counted += frame_bytes.size();
         end
         settle_until_drained();
      end

      // Let any stray result show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && frame_results_due.size() == 0) begin
         $display("[addressed_frame_receiver_crc16] OK");
      end else begin
         $display("[addressed_frame_receiver_crc16] ERROR");
      end
      $finish;
   end

endmodule
